### rtl/core/mcsad_pkg.sv
// ----------------------------------------------------------------------------
// mcsad_pkg
// Sizes, field widths, codes and helpers shared by the mean-compensated
// template match block and its interfaces.
// ----------------------------------------------------------------------------
package mcsad_pkg;

  localparam int MAX_TEMPLATE_W = 64;
  localparam int MAX_TEMPLATE_H = 64;
  localparam int MAX_WINDOW_W   = 128;
  localparam int MAX_WINDOW_H   = 128;

  // fixed field widths of the ports
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int TCFG_W     = 7;
  localparam int WCFG_W     = 8;
  localparam int POS_W      = 12;
  localparam int PIX_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int OFF_W      = 7;
  localparam int CTR_W      = 13;
  localparam int ERR_W      = 21;
  localparam int SCORE_W    = 15;
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  // dimensions in use after clamping
  localparam int TDIM_W = $clog2((MAX_TEMPLATE_W > MAX_TEMPLATE_H ?
                                  MAX_TEMPLATE_W : MAX_TEMPLATE_H) + 1);
  localparam int WDIM_W = $clog2((MAX_WINDOW_W > MAX_WINDOW_H ?
                                  MAX_WINDOW_W : MAX_WINDOW_H) + 1);

  // stores
  localparam int TS_DEPTH = MAX_TEMPLATE_W * MAX_TEMPLATE_H;
  localparam int WS_DEPTH = MAX_WINDOW_W * MAX_WINDOW_H;
  localparam int TA_W     = $clog2(TS_DEPTH);
  localparam int WA_W     = $clog2(WS_DEPTH);
  localparam int TCNT_W   = $clog2(TS_DEPTH + 1);
  localparam int WCNT_W   = $clog2(WS_DEPTH + 1);

  // accumulators and divider
  localparam int SUM_W   = TCNT_W + PIX_W;
  localparam int ACC_W   = TCNT_W + PIX_W + 1;
  localparam int DEN_W   = TCNT_W + PIX_W;
  localparam int SCALE_W = 15;
  localparam int DIV_N_W = DEN_W + 1 + SCALE_W - 1;
  localparam int DCNT_W  = $clog2(DIV_N_W + 1);
  localparam int RES_W   = PIX_W + 3;
  localparam int SCORE_SCALE = 10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPLATE_W = 3'd0,
    REG_TEMPLATE_H = 3'd1,
    REG_WINDOW_W   = 3'd2,
    REG_WINDOW_H   = 3'd3,
    REG_WINDOW_L   = 3'd4,
    REG_WINDOW_T   = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_POINTS = 2'd1,
    STATUS_TOO_SMALL = 2'd2
  } status_t;

  localparam logic CMD_TEMPLATE = 1'b0;
  localparam logic CMD_WINDOW   = 1'b1;

  // clamp a dimension register to 1..hi
  function automatic logic [WDIM_W-1:0] clamp_dim(input logic [WCFG_W-1:0] v,
                                                  input int hi);
    logic [WDIM_W-1:0] r;
    if (v == '0) r = WDIM_W'(1);
    else if (int'(v) > hi) r = WDIM_W'(hi);
    else r = WDIM_W'(v);
    return r;
  endfunction

endpackage

### rtl/core/mcsad_if.sv
// ----------------------------------------------------------------------------
// mcsad channel interfaces
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface mcsad_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [mcsad_pkg::PIX_W-1:0]    pixel;
  logic                           inspect_point;

  modport source (output valid, command, pixel, inspect_point, input ready);
  modport sink   (input valid, command, pixel, inspect_point, output ready);
endinterface

interface mcsad_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcsad_pkg::STATUS_W-1:0]   status;
  logic [mcsad_pkg::OFF_W-1:0]      offset_x;
  logic [mcsad_pkg::OFF_W-1:0]      offset_y;
  logic [mcsad_pkg::CTR_W-1:0]      center_x;
  logic [mcsad_pkg::CTR_W-1:0]      center_y;
  logic [mcsad_pkg::ERR_W-1:0]      total_error;
  logic [mcsad_pkg::ERR_W-1:0]      light_error;
  logic [mcsad_pkg::ERR_W-1:0]      dark_error;
  logic signed [mcsad_pkg::SCORE_W-1:0] match_score;

  modport source (output valid, status, offset_x, offset_y, center_x, center_y,
                  total_error, light_error, dark_error, match_score, input ready);
  modport sink   (input valid, status, offset_x, offset_y, center_x, center_y,
                  total_error, light_error, dark_error, match_score, output ready);
endinterface

interface mcsad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mcsad_pkg::CFG_IDX_W-1:0]   index;
  logic [mcsad_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mcsad_ram.sv
// ----------------------------------------------------------------------------
// mcsad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcsad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mean_compensated_sad_template_match.sv
// ----------------------------------------------------------------------------
// mean_compensated_sad_template_match
// Mean-compensated SAD match of a trained template over a search window.
// ----------------------------------------------------------------------------
// usage
//   cfg_ch : register writes (index, data), always ready; write only while idle
//   in_ch  : template pixels (command 0) then window pixels (command 1), raster
//            order; one item per cycle while no search is running
//   out_ch : one result item after the last window pixel of each window
// search
//   the item completing the window starts a search during which in_ch.ready
//   is low; its length grows with the template pixels and the placements and
//   is set by the single read port of each store and the shared
//   one-bit-per-cycle divider
// reset
//   registers return to 1x1 template and window at (0,0), load indexes to 0;
//   the pixel stores are not cleared
// stall
//   the result sits in an output register until taken; loading continues
//   meanwhile, and a next search holds its result until the register is free
// ----------------------------------------------------------------------------
module mean_compensated_sad_template_match (
  input  logic               clk,
  input  logic               rst_n,
  mcsad_in_if.sink           in_ch,
  mcsad_out_if.source        out_ch,
  mcsad_cfg_if.sink          cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_COUNT, S_TDIV, S_NEXT, S_ISUM, S_IDIV, S_RES, S_CMP,
    S_MUL, S_SABS, S_SDIV, S_OUT
  } state_t;

  localparam logic signed [mcsad_pkg::DIV_N_W:0] SCALE_X =
    (mcsad_pkg::DIV_N_W + 1)'(mcsad_pkg::SCORE_SCALE);

  state_t state_r;

  // configuration registers
  logic [mcsad_pkg::TCFG_W-1:0] tw_cfg_r, th_cfg_r;
  logic [mcsad_pkg::WCFG_W-1:0] ww_cfg_r, wh_cfg_r;
  logic [mcsad_pkg::POS_W-1:0]  wl_r, wt_r;

  // clamped sizes
  logic [mcsad_pkg::TDIM_W-1:0] tw, th;
  logic [mcsad_pkg::WDIM_W-1:0] ww, wh, rx_lim, ry_lim;
  logic [mcsad_pkg::TCNT_W-1:0] tcnt;
  logic [mcsad_pkg::WCNT_W-1:0] wcnt;
  logic                         too_small;

  // loading
  logic [mcsad_pkg::TA_W-1:0]   tld_r, tld_eff, tld_nxt;
  logic [mcsad_pkg::TCNT_W-1:0] tld_inc;
  logic [mcsad_pkg::WA_W-1:0]   wld_r;
  logic [mcsad_pkg::WCNT_W-1:0] wld_inc;
  logic                         in_acc, t_we, w_we, wrap;

  // stores
  logic [mcsad_pkg::PIX_W:0]    t_rd;
  logic [mcsad_pkg::PIX_W-1:0]  w_rd;
  logic [mcsad_pkg::WA_W-1:0]   w_raddr;

  // sweep over the template footprint
  logic [mcsad_pkg::TDIM_W-1:0] x_r, y_r;
  logic [mcsad_pkg::TA_W-1:0]   tidx_r;
  logic [mcsad_pkg::WA_W-1:0]   wrow_r;
  logic                         iss_on_r, iss_last, rd_v_r, rd_last_r;

  // placement
  logic [mcsad_pkg::WDIM_W-1:0] rx_r, ry_r;
  logic [mcsad_pkg::WA_W-1:0]   prow_r, pbase;

  // accumulators
  logic [mcsad_pkg::TCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [mcsad_pkg::SUM_W-1:0]  psum_r, psum_nxt, isum_r, isum_nxt;
  logic [mcsad_pkg::PIX_W-1:0]  tavg_r;
  logic signed [mcsad_pkg::RES_W-1:0] gap_r, resid;
  logic [mcsad_pkg::ACC_W-1:0]  rmag, tot_r, lt_r, dk_r;
  logic                         is_pt;

  // best placement
  logic                         have_r;
  logic [mcsad_pkg::WDIM_W-1:0] best_rx_r, best_ry_r;
  logic [mcsad_pkg::ACC_W-1:0]  best_tot_r, best_lt_r, best_dk_r;

  // score
  logic [mcsad_pkg::DEN_W-1:0]        den;
  logic signed [mcsad_pkg::ACC_W:0]   diff;
  logic signed [mcsad_pkg::DIV_N_W:0] diff_x, prod_r;
  logic                               neg_r;
  logic [mcsad_pkg::SCORE_W-1:0]      score_r;
  mcsad_pkg::status_t                 st_r;
  logic                               ok;

  // shared restoring divider
  logic [mcsad_pkg::DIV_N_W-1:0] div_quo_r;
  logic [mcsad_pkg::DEN_W-1:0]   div_rem_r, div_den_r;
  logic [mcsad_pkg::DCNT_W-1:0]  div_cnt_r;
  logic [mcsad_pkg::DEN_W:0]     rem_sh, rem_sub;
  logic                          div_ge;

  // output register
  logic                              out_valid_r;
  mcsad_pkg::status_t                o_status_r;
  logic [mcsad_pkg::OFF_W-1:0]       o_ox_r, o_oy_r;
  logic [mcsad_pkg::CTR_W-1:0]       o_cx_r, o_cy_r;
  logic [mcsad_pkg::ERR_W-1:0]       o_tot_r, o_lt_r, o_dk_r;
  logic [mcsad_pkg::SCORE_W-1:0]     o_score_r;

  function automatic logic [mcsad_pkg::ERR_W-1:0] sat_err(
    input logic [mcsad_pkg::ACC_W-1:0] v);
    logic [mcsad_pkg::ERR_W-1:0] r;
    if (v > mcsad_pkg::ACC_W'(mcsad_pkg::ERR_MAX)) r = mcsad_pkg::ERR_MAX;
    else r = v[mcsad_pkg::ERR_W-1:0];
    return r;
  endfunction

  // sizes in use
  assign tw = mcsad_pkg::TDIM_W'(mcsad_pkg::clamp_dim(
                mcsad_pkg::WCFG_W'(tw_cfg_r), mcsad_pkg::MAX_TEMPLATE_W));
  assign th = mcsad_pkg::TDIM_W'(mcsad_pkg::clamp_dim(
                mcsad_pkg::WCFG_W'(th_cfg_r), mcsad_pkg::MAX_TEMPLATE_H));
  assign ww = mcsad_pkg::clamp_dim(ww_cfg_r, mcsad_pkg::MAX_WINDOW_W);
  assign wh = mcsad_pkg::clamp_dim(wh_cfg_r, mcsad_pkg::MAX_WINDOW_H);
  assign tcnt = mcsad_pkg::TCNT_W'(tw) * mcsad_pkg::TCNT_W'(th);
  assign wcnt = mcsad_pkg::WCNT_W'(ww) * mcsad_pkg::WCNT_W'(wh);
  assign too_small = (wh < mcsad_pkg::WDIM_W'(th)) || (ww < mcsad_pkg::WDIM_W'(tw));
  assign rx_lim = ww - mcsad_pkg::WDIM_W'(tw);
  assign ry_lim = wh - mcsad_pkg::WDIM_W'(th);

  // load indexing: template index wraps early if the size shrank
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign t_we    = in_acc && (in_ch.command == mcsad_pkg::CMD_TEMPLATE);
  assign w_we    = in_acc && (in_ch.command == mcsad_pkg::CMD_WINDOW);
  assign tld_eff = (mcsad_pkg::TCNT_W'(tld_r) >= tcnt) ? '0 : tld_r;
  assign tld_inc = mcsad_pkg::TCNT_W'(tld_eff) + 1'b1;
  assign tld_nxt = (tld_inc >= tcnt) ? '0 : tld_inc[mcsad_pkg::TA_W-1:0];
  assign wld_inc = mcsad_pkg::WCNT_W'(wld_r) + 1'b1;
  assign wrap    = wld_inc >= wcnt;

  assign w_raddr  = wrow_r + mcsad_pkg::WA_W'(x_r);
  assign iss_last = (x_r == tw - 1'b1) && (y_r == th - 1'b1);
  assign pbase    = prow_r + mcsad_pkg::WA_W'(rx_r);

  mcsad_ram #(.WIDTH(mcsad_pkg::PIX_W + 1), .DEPTH(mcsad_pkg::TS_DEPTH)) u_tstore (
    .clk   (clk),
    .we    (t_we),
    .waddr (tld_eff),
    .wdata ({in_ch.inspect_point, in_ch.pixel}),
    .raddr (tidx_r),
    .rdata (t_rd)
  );

  mcsad_ram #(.WIDTH(mcsad_pkg::PIX_W), .DEPTH(mcsad_pkg::WS_DEPTH)) u_wstore (
    .clk   (clk),
    .we    (w_we),
    .waddr (wld_r),
    .wdata (in_ch.pixel),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  // datapath for the data coming back from the stores
  always_comb begin
    is_pt    = t_rd[mcsad_pkg::PIX_W];
    pcnt_nxt = pcnt_r + mcsad_pkg::TCNT_W'(is_pt);
    psum_nxt = is_pt ? psum_r + mcsad_pkg::SUM_W'(t_rd[mcsad_pkg::PIX_W-1:0]) : psum_r;
    isum_nxt = is_pt ? isum_r + mcsad_pkg::SUM_W'(w_rd) : isum_r;
    // residual: window pixel minus mean gap minus template pixel
    resid = $signed(mcsad_pkg::RES_W'(w_rd)) - gap_r
          - $signed(mcsad_pkg::RES_W'(t_rd[mcsad_pkg::PIX_W-1:0]));
    rmag  = resid[mcsad_pkg::RES_W-1] ? mcsad_pkg::ACC_W'(-resid)
                                      : mcsad_pkg::ACC_W'(resid);
    // one quotient bit per step
    rem_sh  = {div_rem_r, div_quo_r[mcsad_pkg::DIV_N_W-1]};
    div_ge  = rem_sh >= {1'b0, div_den_r};
    rem_sub = rem_sh - {1'b0, div_den_r};
    // score numerator
    den    = {pcnt_r, {mcsad_pkg::PIX_W{1'b0}}};
    diff   = $signed({1'b0, mcsad_pkg::ACC_W'(den)}) - $signed({1'b0, best_tot_r});
    diff_x = (mcsad_pkg::DIV_N_W + 1)'(diff);
    ok     = st_r == mcsad_pkg::STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tw_cfg_r    <= mcsad_pkg::TCFG_W'(1);
      th_cfg_r    <= mcsad_pkg::TCFG_W'(1);
      ww_cfg_r    <= mcsad_pkg::WCFG_W'(1);
      wh_cfg_r    <= mcsad_pkg::WCFG_W'(1);
      wl_r        <= '0;
      wt_r        <= '0;
      tld_r       <= '0;
      wld_r       <= '0;
      iss_on_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      // register writes
      if (cfg_ch.valid) begin
        unique case (mcsad_pkg::cfg_reg_t'(cfg_ch.index))
          mcsad_pkg::REG_TEMPLATE_W: tw_cfg_r <= cfg_ch.data[mcsad_pkg::TCFG_W-1:0];
          mcsad_pkg::REG_TEMPLATE_H: th_cfg_r <= cfg_ch.data[mcsad_pkg::TCFG_W-1:0];
          mcsad_pkg::REG_WINDOW_W:   ww_cfg_r <= cfg_ch.data[mcsad_pkg::WCFG_W-1:0];
          mcsad_pkg::REG_WINDOW_H:   wh_cfg_r <= cfg_ch.data[mcsad_pkg::WCFG_W-1:0];
          mcsad_pkg::REG_WINDOW_L:   wl_r     <= cfg_ch.data[mcsad_pkg::POS_W-1:0];
          mcsad_pkg::REG_WINDOW_T:   wt_r     <= cfg_ch.data[mcsad_pkg::POS_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;

      // address issue, read data comes back in the following cycle
      rd_v_r    <= iss_on_r;
      rd_last_r <= iss_on_r && iss_last;
      if (iss_on_r) begin
        tidx_r <= tidx_r + 1'b1;
        if (x_r == tw - 1'b1) begin
          x_r    <= '0;
          y_r    <= y_r + 1'b1;
          wrow_r <= wrow_r + mcsad_pkg::WA_W'(ww);
        end else begin
          x_r <= x_r + 1'b1;
        end
        if (iss_last) iss_on_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (t_we) tld_r <= tld_nxt;
          if (w_we) begin
            wld_r <= wrap ? '0 : wld_inc[mcsad_pkg::WA_W-1:0];
            if (wrap) begin
              if (too_small) begin
                st_r    <= mcsad_pkg::STATUS_TOO_SMALL;
                state_r <= S_OUT;
              end else begin
                st_r     <= mcsad_pkg::STATUS_OK;
                pcnt_r   <= '0;
                psum_r   <= '0;
                x_r      <= '0;
                y_r      <= '0;
                tidx_r   <= '0;
                wrow_r   <= '0;
                iss_on_r <= 1'b1;
                state_r  <= S_COUNT;
              end
            end
          end
        end

        // count inspection points and their template sum
        S_COUNT: begin
          if (rd_v_r) begin
            pcnt_r <= pcnt_nxt;
            psum_r <= psum_nxt;
            if (rd_last_r) begin
              if (pcnt_nxt == '0) begin
                st_r    <= mcsad_pkg::STATUS_NO_POINTS;
                state_r <= S_OUT;
              end else begin
                div_quo_r <= mcsad_pkg::DIV_N_W'(psum_nxt);
                div_rem_r <= '0;
                div_den_r <= mcsad_pkg::DEN_W'(pcnt_nxt);
                div_cnt_r <= mcsad_pkg::DCNT_W'(mcsad_pkg::DIV_N_W);
                state_r   <= S_TDIV;
              end
            end
          end
        end

        S_TDIV: begin
          if (div_cnt_r != '0) begin
            div_cnt_r <= div_cnt_r - 1'b1;
            div_quo_r <= {div_quo_r[mcsad_pkg::DIV_N_W-2:0], div_ge};
            div_rem_r <= div_ge ? rem_sub[mcsad_pkg::DEN_W-1:0]
                                : rem_sh[mcsad_pkg::DEN_W-1:0];
          end else begin
            tavg_r  <= div_quo_r[mcsad_pkg::PIX_W-1:0];
            rx_r    <= '0;
            ry_r    <= '0;
            prow_r  <= '0;
            have_r  <= 1'b0;
            state_r <= S_NEXT;
          end
        end

        // start a placement: sum window pixels under the points
        S_NEXT: begin
          isum_r   <= '0;
          x_r      <= '0;
          y_r      <= '0;
          tidx_r   <= '0;
          wrow_r   <= pbase;
          iss_on_r <= 1'b1;
          state_r  <= S_ISUM;
        end

        S_ISUM: begin
          if (rd_v_r) begin
            isum_r <= isum_nxt;
            if (rd_last_r) begin
              div_quo_r <= mcsad_pkg::DIV_N_W'(isum_nxt);
              div_rem_r <= '0;
              div_den_r <= mcsad_pkg::DEN_W'(pcnt_r);
              div_cnt_r <= mcsad_pkg::DCNT_W'(mcsad_pkg::DIV_N_W);
              state_r   <= S_IDIV;
            end
          end
        end

        S_IDIV: begin
          if (div_cnt_r != '0) begin
            div_cnt_r <= div_cnt_r - 1'b1;
            div_quo_r <= {div_quo_r[mcsad_pkg::DIV_N_W-2:0], div_ge};
            div_rem_r <= div_ge ? rem_sub[mcsad_pkg::DEN_W-1:0]
                                : rem_sh[mcsad_pkg::DEN_W-1:0];
          end else begin
            gap_r <= $signed(mcsad_pkg::RES_W'(div_quo_r[mcsad_pkg::PIX_W-1:0]))
                   - $signed(mcsad_pkg::RES_W'(tavg_r));
            tot_r    <= '0;
            lt_r     <= '0;
            dk_r     <= '0;
            x_r      <= '0;
            y_r      <= '0;
            tidx_r   <= '0;
            wrow_r   <= pbase;
            iss_on_r <= 1'b1;
            state_r  <= S_RES;
          end
        end

        // total, light and dark residual sums
        S_RES: begin
          if (rd_v_r) begin
            if (is_pt) begin
              tot_r <= tot_r + rmag;
              if (resid > 0) lt_r <= lt_r + rmag;
              else dk_r <= dk_r + rmag;
            end
            if (rd_last_r) state_r <= S_CMP;
          end
        end

        // keep the first strictly smaller total, then step the placement
        S_CMP: begin
          if (!have_r || (tot_r < best_tot_r)) begin
            best_rx_r  <= rx_r;
            best_ry_r  <= ry_r;
            best_tot_r <= tot_r;
            best_lt_r  <= lt_r;
            best_dk_r  <= dk_r;
          end
          have_r <= 1'b1;
          if (rx_r == rx_lim) begin
            if (ry_r == ry_lim) begin
              state_r <= S_MUL;
            end else begin
              rx_r    <= '0;
              ry_r    <= ry_r + 1'b1;
              prow_r  <= prow_r + mcsad_pkg::WA_W'(ww);
              state_r <= S_NEXT;
            end
          end else begin
            rx_r    <= rx_r + 1'b1;
            state_r <= S_NEXT;
          end
        end

        S_MUL: begin
          prod_r  <= diff_x * SCALE_X;
          state_r <= S_SABS;
        end

        // divide magnitudes, sign restored after
        S_SABS: begin
          neg_r     <= prod_r[mcsad_pkg::DIV_N_W];
          div_quo_r <= prod_r[mcsad_pkg::DIV_N_W] ? mcsad_pkg::DIV_N_W'(-prod_r)
                                                   : mcsad_pkg::DIV_N_W'(prod_r);
          div_rem_r <= '0;
          div_den_r <= den;
          div_cnt_r <= mcsad_pkg::DCNT_W'(mcsad_pkg::DIV_N_W);
          state_r   <= S_SDIV;
        end

        S_SDIV: begin
          if (div_cnt_r != '0) begin
            div_cnt_r <= div_cnt_r - 1'b1;
            div_quo_r <= {div_quo_r[mcsad_pkg::DIV_N_W-2:0], div_ge};
            div_rem_r <= div_ge ? rem_sub[mcsad_pkg::DEN_W-1:0]
                                : rem_sh[mcsad_pkg::DEN_W-1:0];
          end else begin
            score_r <= neg_r ? mcsad_pkg::SCORE_W'(-div_quo_r)
                             : mcsad_pkg::SCORE_W'(div_quo_r);
            state_r <= S_OUT;
          end
        end

        // wait for the output register to be free
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_status_r  <= st_r;
            o_ox_r      <= ok ? mcsad_pkg::OFF_W'(best_rx_r) : '0;
            o_oy_r      <= ok ? mcsad_pkg::OFF_W'(best_ry_r) : '0;
            o_cx_r      <= ok ? mcsad_pkg::CTR_W'(wl_r) + mcsad_pkg::CTR_W'(best_rx_r)
                                + mcsad_pkg::CTR_W'(tw >> 1) : '0;
            o_cy_r      <= ok ? mcsad_pkg::CTR_W'(wt_r) + mcsad_pkg::CTR_W'(best_ry_r)
                                + mcsad_pkg::CTR_W'(th >> 1) : '0;
            o_tot_r     <= ok ? sat_err(best_tot_r) : '0;
            o_lt_r      <= ok ? sat_err(best_lt_r) : '0;
            o_dk_r      <= ok ? sat_err(best_dk_r) : '0;
            o_score_r   <= ok ? score_r : '0;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = state_r == S_IDLE;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.offset_x    = o_ox_r;
  assign out_ch.offset_y    = o_oy_r;
  assign out_ch.center_x    = o_cx_r;
  assign out_ch.center_y    = o_cy_r;
  assign out_ch.total_error = o_tot_r;
  assign out_ch.light_error = o_lt_r;
  assign out_ch.dark_error  = o_dk_r;
  assign out_ch.match_score = o_score_r;

  // store read data only returns during a sweep
  a_rd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_COUNT || state_r == S_ISUM || state_r == S_RES))
    else $error("store read data outside a sweep");

  // divisions by the point count only happen with points present
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDIV || state_r == S_SDIV) |-> (pcnt_r != '0))
    else $error("division by zero point count");

  // a result only appears out of the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result without finished search");

  // no new item is taken while a search runs
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_on_r || rd_v_r) |-> !in_ch.ready)
    else $error("input accepted during search");

endmodule

### sim/tb_mean_compensated_sad_template_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mean_compensated_sad_template_match
// Self-checking bench for the mean-compensated SAD template match. Templates
// and windows are streamed over the pixel channel under random idling and one
// long result back-pressure stretch. A behavioral copy of the search predicts
// every result, which is checked field by field against the output channel.
// ----------------------------------------------------------------------------
module tb_mean_compensated_sad_template_match;
  import mcsad_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int LONG_HOLD    = 2500;

  typedef struct {
    logic       command;
    logic [7:0] pixel;
    logic       inspect;
  } pixel_item_t;

  typedef struct packed {
    status_t                   status;
    logic [OFF_W-1:0]          offset_x;
    logic [OFF_W-1:0]          offset_y;
    logic [CTR_W-1:0]          center_x;
    logic [CTR_W-1:0]          center_y;
    logic [ERR_W-1:0]          total_error;
    logic [ERR_W-1:0]          light_error;
    logic [ERR_W-1:0]          dark_error;
    logic signed [SCORE_W-1:0] match_score;
  } match_result_t;

  logic clk;
  logic rst_n;

  mcsad_in_if  in_if();
  mcsad_out_if out_if();
  mcsad_cfg_if cfg_if();

  mean_compensated_sad_template_match u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // pixels waiting to be driven, and match results the search should produce
  pixel_item_t   pixel_queue[$];
  match_result_t expected_matches[$];

  // predicted block state
  logic [6:0]  tpl_w_reg, tpl_h_reg;
  logic [7:0]  win_w_reg, win_h_reg;
  logic [11:0] win_left_reg, win_top_reg;
  logic [8:0]  tpl_mem [TS_DEPTH];
  logic [7:0]  win_mem [WS_DEPTH];
  int unsigned tpl_load_idx, win_load_idx;

  // run bookkeeping
  int  fail_count;
  int  pixels_taken;
  int  matches_seen;
  int  reg_writes;
  int  phases_run;
  bit  hold_request;

  // own clamp of a dimension register to 1..hi
  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ERR_W-1:0] clip_err(int unsigned v);
    return (v > ERR_MAX) ? ERR_MAX : ERR_W'(v);
  endfunction

  // full placement search over the predicted stores
  function automatic match_result_t search_window();
    int unsigned tw, th, ww, wh, npts, tsum, tavg, isum;
    int unsigned err, lt, dk, best_err, best_lt, best_dk, bx, by;
    int unsigned waddr;
    int          gap, r;
    bit          have;
    longint      den, num;
    match_result_t res;
    res = '0;
    tw = clip_dim(tpl_w_reg, MAX_TEMPLATE_W);
    th = clip_dim(tpl_h_reg, MAX_TEMPLATE_H);
    ww = clip_dim(win_w_reg, MAX_WINDOW_W);
    wh = clip_dim(win_h_reg, MAX_WINDOW_H);
    // size check comes before anything is read
    if (wh < th || ww < tw) begin
      res.status = STATUS_TOO_SMALL;
      return res;
    end
    npts = 0;
    tsum = 0;
    for (int y = 0; y < th; y++)
      for (int x = 0; x < tw; x++)
        if (tpl_mem[y*tw+x][8]) begin
          npts++;
          tsum += tpl_mem[y*tw+x][7:0];
        end
    if (npts == 0) begin
      res.status = STATUS_NO_POINTS;
      return res;
    end
    tavg = tsum / npts;
    have = 0;
    best_err = 0; best_lt = 0; best_dk = 0; bx = 0; by = 0;
    for (int ry = 0; ry <= wh - th; ry++)
      for (int rx = 0; rx <= ww - tw; rx++) begin
        isum = 0;
        for (int y = 0; y < th; y++)
          for (int x = 0; x < tw; x++)
            if (tpl_mem[y*tw+x][8]) begin
              waddr = ((ry + y) * ww + rx + x) % WS_DEPTH;
              isum += win_mem[waddr];
            end
        // brightness offset between window and template inspection points
        gap = int'(isum / npts) - int'(tavg);
        err = 0; lt = 0; dk = 0;
        for (int y = 0; y < th; y++)
          for (int x = 0; x < tw; x++)
            if (tpl_mem[y*tw+x][8]) begin
              waddr = ((ry + y) * ww + rx + x) % WS_DEPTH;
              r = int'(win_mem[waddr]) - gap - int'(tpl_mem[y*tw+x][7:0]);
              if (r > 0) begin
                lt += r;
                err += r;
              end else begin
                dk += -r;
                err += -r;
              end
            end
        // strict less-than keeps the first placement in raster order on a tie
        if (!have || err < best_err) begin
          have = 1;
          best_err = err; best_lt = lt; best_dk = dk; bx = rx; by = ry;
        end
      end
    den = longint'(npts) * 256;
    num = (den - longint'(best_err)) * 10000;
    res.status      = STATUS_OK;
    res.offset_x    = OFF_W'(bx);
    res.offset_y    = OFF_W'(by);
    res.center_x    = CTR_W'(win_left_reg + bx + tw / 2);
    res.center_y    = CTR_W'(win_top_reg + by + th / 2);
    res.total_error = clip_err(best_err);
    res.light_error = clip_err(best_lt);
    res.dark_error  = clip_err(best_dk);
    res.match_score = SCORE_W'(num / den);
    return res;
  endfunction

  // state update for one accepted pixel item
  function automatic void take_pixel(pixel_item_t it);
    int unsigned cnt;
    if (it.command == CMD_TEMPLATE) begin
      cnt = clip_dim(tpl_w_reg, MAX_TEMPLATE_W) * clip_dim(tpl_h_reg, MAX_TEMPLATE_H);
      if (tpl_load_idx >= cnt) tpl_load_idx = 0;
      tpl_mem[tpl_load_idx % TS_DEPTH] = {it.inspect, it.pixel};
      tpl_load_idx++;
      if (tpl_load_idx >= cnt) tpl_load_idx = 0;
    end else begin
      cnt = clip_dim(win_w_reg, MAX_WINDOW_W) * clip_dim(win_h_reg, MAX_WINDOW_H);
      win_mem[win_load_idx % WS_DEPTH] = it.pixel;
      win_load_idx++;
      if (win_load_idx >= cnt) begin
        win_load_idx = 0;
        expected_matches.push_back(search_window());
      end
    end
  endfunction

  // clock, with every block input known from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_TEMPLATE;
    in_if.pixel = '0;
    in_if.inspect_point = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TEMPLATE_W;
    cfg_if.data = '0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver
  pixel_item_t on_bus;
  int          send_gap;
  bit          send_steady;

  always @(posedge clk) begin
    pixel_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      // item on the bus taken at this edge
      if (in_if.valid && in_if.ready) begin
        take_pixel(on_bus);
        pixels_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          nxt = pixel_queue.pop_front();
          on_bus = nxt;
          in_if.valid <= 1'b1;
          in_if.command <= nxt.command;
          in_if.pixel <= nxt.pixel;
          in_if.inspect_point <= nxt.inspect;
          // now and then switch between idling and back-to-back stretches
          if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
          send_gap <= send_steady ? 0 : $urandom_range(0, 7);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int recv_wait;
  int recv_long;
  bit recv_steady;

  always @(posedge clk) begin
    match_result_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_wait = 0;
      recv_long = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status      = status_t'(out_if.status);
        got.offset_x    = out_if.offset_x;
        got.offset_y    = out_if.offset_y;
        got.center_x    = out_if.center_x;
        got.center_y    = out_if.center_y;
        got.total_error = out_if.total_error;
        got.light_error = out_if.light_error;
        got.dark_error  = out_if.dark_error;
        got.match_score = out_if.match_score;
        matches_seen++;
        if (expected_matches.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected match item, status %0d", $realtime, got.status);
        end else begin
          want = expected_matches.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] match %0d differs (expected / actual):", $realtime,
                       matches_seen);
              $display("  status %0d/%0d off %0d,%0d/%0d,%0d ctr %0d,%0d/%0d,%0d",
                       want.status, got.status, want.offset_x, want.offset_y,
                       got.offset_x, got.offset_y, want.center_x, want.center_y,
                       got.center_x, got.center_y);
              $display("  total %0d/%0d light %0d/%0d dark %0d/%0d score %0d/%0d",
                       want.total_error, got.total_error, want.light_error,
                       got.light_error, want.dark_error, got.dark_error,
                       want.match_score, got.match_score);
            end
          end
        end
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 7);
      end
      // long hold-off so results back up and the pixel input stalls
      if (recv_long > 0) begin
        recv_long--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        recv_long = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_TEMPLATE_W: tpl_w_reg = val[6:0];
      REG_TEMPLATE_H: tpl_h_reg = val[6:0];
      REG_WINDOW_W:   win_w_reg = val[7:0];
      REG_WINDOW_H:   win_h_reg = val[7:0];
      REG_WINDOW_L:   win_left_reg = val[11:0];
      REG_WINDOW_T:   win_top_reg = val[11:0];
      default: ;
    endcase
    reg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // all pixels taken, all results back, then a short settle
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_if.valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [7:0] draw_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_pixel(logic cmd, logic [7:0] px, logic ip);
    pixel_item_t it;
    it.command = cmd;
    it.pixel = px;
    it.inspect = ip;
    pixel_queue.push_back(it);
  endfunction

  // one setting: registers, a full template, then whole windows
  task automatic run_phase(int tw, int th, int ww, int wh, int wl, int wt,
                           int windows, int point_pct, bit noise);
    int unsigned tcnt, wcnt;
    wait_idle();
    write_reg(REG_TEMPLATE_W, tw);
    write_reg(REG_TEMPLATE_H, th);
    write_reg(REG_WINDOW_W, ww);
    write_reg(REG_WINDOW_H, wh);
    write_reg(REG_WINDOW_L, wl);
    write_reg(REG_WINDOW_T, wt);
    tcnt = clip_dim(tw[6:0], MAX_TEMPLATE_W) * clip_dim(th[6:0], MAX_TEMPLATE_H);
    wcnt = clip_dim(ww[7:0], MAX_WINDOW_W) * clip_dim(wh[7:0], MAX_WINDOW_H);
    // a full pass from any load position writes every template entry
    repeat (tcnt)
      queue_pixel(CMD_TEMPLATE, draw_pixel(), $urandom_range(0, 99) < point_pct);
    repeat (windows) begin
      for (int i = 0; i < wcnt; i++) begin
        // stray template rewrites in the middle of a window
        if (noise && $urandom_range(0, 19) == 0)
          queue_pixel(CMD_TEMPLATE, draw_pixel(), $urandom_range(0, 1));
        queue_pixel(CMD_WINDOW, draw_pixel(), $urandom_range(0, 1));
      end
    end
    phases_run++;
  endtask

  initial begin
    int tw, th, ww, wh, pct;
    tpl_w_reg = 7'd1; tpl_h_reg = 7'd1;
    win_w_reg = 8'd1; win_h_reg = 8'd1;
    win_left_reg = '0; win_top_reg = '0;
    tpl_load_idx = 0; win_load_idx = 0;
    fail_count = 0; pixels_taken = 0; matches_seen = 0;
    reg_writes = 0; phases_run = 0;
    hold_request = 1'b0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single pixel at reset sizes, pixel extremes
    queue_pixel(CMD_TEMPLATE, 8'd255, 1'b1);
    queue_pixel(CMD_WINDOW, 8'd0, 1'b0);
    queue_pixel(CMD_WINDOW, 8'd255, 1'b1);
    // 2x2 template in a 3x2 window at the far image corner, centers pass 4095
    wait_idle();
    write_reg(REG_TEMPLATE_W, 2);
    write_reg(REG_TEMPLATE_H, 2);
    write_reg(REG_WINDOW_W, 3);
    write_reg(REG_WINDOW_H, 2);
    write_reg(REG_WINDOW_L, 12'hfff);
    write_reg(REG_WINDOW_T, 12'hfff);
    queue_pixel(CMD_TEMPLATE, 8'd0, 1'b1);
    queue_pixel(CMD_TEMPLATE, 8'd255, 1'b1);
    queue_pixel(CMD_TEMPLATE, 8'd128, 1'b0);
    queue_pixel(CMD_TEMPLATE, 8'd255, 1'b1);
    queue_pixel(CMD_WINDOW, 8'd255, 1'b0);
    queue_pixel(CMD_WINDOW, 8'd0, 1'b1);
    queue_pixel(CMD_WINDOW, 8'd255, 1'b0);
    queue_pixel(CMD_WINDOW, 8'd7, 1'b1);
    queue_pixel(CMD_WINDOW, 8'd0, 1'b0);
    queue_pixel(CMD_WINDOW, 8'd255, 1'b1);
    // template without inspection points
    repeat (4) queue_pixel(CMD_TEMPLATE, 8'd200, 1'b0);
    repeat (6) queue_pixel(CMD_WINDOW, 8'd50, 1'b1);
    // window narrower than template
    wait_idle();
    write_reg(REG_WINDOW_W, 1);
    queue_pixel(CMD_WINDOW, 8'd1, 1'b0);
    queue_pixel(CMD_WINDOW, 8'd2, 1'b0);

    // random part; the first phase runs under the long receiver hold-off
    wait_idle();
    hold_request = 1'b1;
    run_phase(1, 1, 2, 2, 17, 33, 12, 100, 1'b0);
    while (pixels_taken + pixel_queue.size() < RANDOM_ITEMS + 25) begin
      case ($urandom_range(0, 11))
        // widest template and window, registers above range clamp
        0: run_phase(127, 1, 255, 1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     1, 60, 1'b0);
        // tallest template and window
        1: run_phase(1, 64, 1, 128, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     1, 60, 1'b0);
        // zero registers read as one
        2: run_phase(0, 0, 0, 0, 4095, 0, $urandom_range(2, 6), 100, 1'b1);
        // long flat window, many placements
        3: run_phase(2, 1, 128, 2, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     1, 80, 1'b0);
        default: begin
          tw = $urandom_range(1, 4);
          th = $urandom_range(1, 4);
          // mostly windows that fit, sometimes too small
          if ($urandom_range(0, 7) == 0) begin
            ww = $urandom_range(1, 6);
            wh = $urandom_range(1, 6);
          end else begin
            ww = tw + $urandom_range(0, 4);
            wh = th + $urandom_range(0, 3);
          end
          pct = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(20, 100);
          run_phase(tw, th, ww, wh, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(2, 6), pct, 1'b1);
        end
      endcase
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (expected_matches.size() != 0) fail_count += expected_matches.size();
    $display("run covered %0d pixel items, %0d match items, %0d register writes",
             pixels_taken, matches_seen, reg_writes);
    $display("over %0d random settings plus directed corner cases", phases_run);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(64'd30_000_000);
    $display("timeout with %0d match items outstanding", expected_matches.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
